@@ hw/rtl/rdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdsc_pkg
// Shared types, constants and helpers for the radix digit string converter.
// ----------------------------------------------------------------------------
package rdsc_pkg;

	localparam int MAX_DIGITS = 32;
	localparam int DIGIT_CAP  = (MAX_DIGITS < 31) ? MAX_DIGITS : 31;
	localparam int CNT_W      = $clog2(DIGIT_CAP + 1);
	localparam int ADDR_W     = $clog2(DIGIT_CAP);

	localparam int NUM_W      = 32;
	localparam int DIV_W      = NUM_W - 1;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] DEC_LIMIT = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;
	localparam logic [CHAR_W-1:0]  CHAR_NUL  = 7'h00;

	typedef struct packed {
		logic signed [NUM_W-1:0] number_in;
		logic [RADIX_W-1:0]      radix;
	} rdsc_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              last;
		logic              bad_radix;
	} rdsc_out_t;

	typedef struct packed {
		logic               start;
		logic [DIV_W-1:0]   dividend;
		logic [RADIX_W-1:0] divisor;
	} rdsc_div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_W-1:0]   quotient;
		logic [RADIX_W-1:0] remainder;
	} rdsc_div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_POP  = 5'b00100,
		ST_EMIT = 5'b01000,
		ST_TERM = 5'b10000
	} rdsc_state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_LIMIT) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/radix_digit_string_converter_unit.sv @@
// ----------------------------------------------------------------------------
// radix_digit_string_converter_unit
// Converts a signed value to an ASCII digit string in base 2 to 36.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A positive value is
// divided digit by digit in the shared one-bit-per-cycle divider, then each
// character is popped off the digit stack through ST_POP and ST_EMIT, then
// ST_TERM gives the NUL terminator; a value has at most 31 digits.
// A value below one or a radix outside 2..36 gives only the terminator, in the
// cycle right after the command. Each character appears for exactly one cycle
// with strobe high and the receiver cannot stall it; last marks the terminator
// and bad_radix is set on it when the radix was out of range.
// ----------------------------------------------------------------------------
module radix_digit_string_converter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rdsc_pkg::rdsc_in_t  cmd,
	output logic                strobe,
	output rdsc_pkg::rdsc_out_t result
);

	rdsc_pkg::rdsc_state_t           state_q;
	logic [rdsc_pkg::CNT_W-1:0]      cnt_q;
	logic                            bad_q;
	logic [rdsc_pkg::RADIX_W-1:0]    radix_q;

	rdsc_pkg::rdsc_div_req_t         div_req;
	rdsc_pkg::rdsc_div_rsp_t         div_rsp;

	logic                            accept;
	logic                            radix_bad;
	logic                            non_pos;
	logic                            push;
	logic                            pop;
	logic [rdsc_pkg::CNT_W-1:0]      cnt_dec;
	logic [rdsc_pkg::RADIX_W-1:0]    rd_digit;

	assign accept    = start && !busy;
	assign radix_bad = (cmd.radix < rdsc_pkg::RADIX_MIN) || (cmd.radix > rdsc_pkg::RADIX_MAX);
	assign non_pos   = cmd.number_in[rdsc_pkg::NUM_W-1] || (cmd.number_in == '0);
	assign push      = (state_q == rdsc_pkg::ST_DIV) && div_rsp.done
		&& (cnt_q < rdsc_pkg::CNT_W'(rdsc_pkg::DIGIT_CAP));
	assign pop       = (state_q == rdsc_pkg::ST_POP);
	assign cnt_dec   = cnt_q - 1'b1;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = div_rsp.quotient;
		div_req.divisor  = radix_q;
		if ((state_q == rdsc_pkg::ST_IDLE) && accept && !radix_bad && !non_pos) begin
			div_req.start    = 1'b1;
			div_req.dividend = cmd.number_in[rdsc_pkg::DIV_W-1:0];
			div_req.divisor  = cmd.radix;
		end else if ((state_q == rdsc_pkg::ST_DIV) && div_rsp.done
			&& (div_rsp.quotient != '0)) begin
			div_req.start = 1'b1;
		end
	end

	rdsc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rdsc_digit_stack u_stack (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (cnt_q[rdsc_pkg::ADDR_W-1:0]),
		.wr_data (div_rsp.remainder),
		.rd_en   (pop),
		.rd_addr (cnt_dec[rdsc_pkg::ADDR_W-1:0]),
		.rd_data (rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdsc_pkg::ST_IDLE;
			cnt_q   <= '0;
			bad_q   <= 1'b0;
		end else begin
			case (state_q)
				rdsc_pkg::ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						bad_q <= radix_bad;
						if (radix_bad || non_pos) begin
							state_q <= rdsc_pkg::ST_TERM;
						end else begin
							state_q <= rdsc_pkg::ST_DIV;
						end
					end
				end
				rdsc_pkg::ST_DIV: begin
					if (div_rsp.done) begin
						if (push) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (div_rsp.quotient == '0) begin
							state_q <= rdsc_pkg::ST_POP;
						end
					end
				end
				rdsc_pkg::ST_POP: begin
					cnt_q   <= cnt_dec;
					state_q <= rdsc_pkg::ST_EMIT;
				end
				rdsc_pkg::ST_EMIT: begin
					if (cnt_q == '0) begin
						state_q <= rdsc_pkg::ST_TERM;
					end else begin
						state_q <= rdsc_pkg::ST_POP;
					end
				end
				rdsc_pkg::ST_TERM: begin
					state_q <= rdsc_pkg::ST_IDLE;
				end
				default: begin
					state_q <= rdsc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// radix held for the repeated divisions of one command
	always_ff @(posedge clk) begin
		if (accept) begin
			radix_q <= cmd.radix;
		end
	end

	assign busy   = (state_q != rdsc_pkg::ST_IDLE);
	assign strobe = (state_q == rdsc_pkg::ST_EMIT) || (state_q == rdsc_pkg::ST_TERM);

	always_comb begin
		result.char_out  = rdsc_pkg::CHAR_NUL;
		result.last      = 1'b0;
		result.bad_radix = 1'b0;
		if (state_q == rdsc_pkg::ST_EMIT) begin
			result.char_out = rdsc_pkg::digit_char(rd_digit);
		end else if (state_q == rdsc_pkg::ST_TERM) begin
			result.last      = 1'b1;
			result.bad_radix = bad_q;
		end
	end

	a_strobe_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result transfer while idle");

	a_last_frees_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !busy)
		else $error("unit still busy after terminator");

	a_digit_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last)
		|-> (!result.bad_radix && (result.char_out != rdsc_pkg::CHAR_NUL)))
		else $error("digit transfer with terminator fields");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command accepted but unit not busy");

endmodule

@@ hw/rtl/rdsc_divider.sv @@
// ----------------------------------------------------------------------------
// rdsc_divider
// Restoring divider, one quotient bit per cycle, shared by every digit.
// ----------------------------------------------------------------------------
module rdsc_divider (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rdsc_pkg::rdsc_div_req_t req,
	output rdsc_pkg::rdsc_div_rsp_t rsp
);

	logic                            running_q;
	logic                            done_q;
	logic [rdsc_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [rdsc_pkg::DIV_W-1:0]      quo_q;
	logic [rdsc_pkg::RADIX_W-1:0]    rem_q;
	logic [rdsc_pkg::RADIX_W-1:0]    dvs_q;

	logic [rdsc_pkg::RADIX_W:0]      trial;
	logic [rdsc_pkg::RADIX_W:0]      diff;
	logic                            fit;

	assign trial = {rem_q, quo_q[rdsc_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fit   = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				running_q <= 1'b1;
				cnt_q     <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rdsc_pkg::DIV_LAST) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (running_q) begin
			quo_q <= {quo_q[rdsc_pkg::DIV_W-2:0], fit};
			rem_q <= fit ? diff[rdsc_pkg::RADIX_W-1:0] : trial[rdsc_pkg::RADIX_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < dvs_q))
		else $error("remainder not below divisor");

	a_no_restart_while_running: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !running_q)
		else $error("divider restarted mid division");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(running_q) && !running_q))
		else $error("done without a finished division");

endmodule

@@ hw/rtl/rdsc_digit_stack.sv @@
// ----------------------------------------------------------------------------
// rdsc_digit_stack
// Remainder storage, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rdsc_digit_stack (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [rdsc_pkg::ADDR_W-1:0]   wr_addr,
	input  logic [rdsc_pkg::RADIX_W-1:0]  wr_data,
	input  logic                          rd_en,
	input  logic [rdsc_pkg::ADDR_W-1:0]   rd_addr,
	output logic [rdsc_pkg::RADIX_W-1:0]  rd_data
);

	logic [rdsc_pkg::RADIX_W-1:0] mem_q [rdsc_pkg::DIGIT_CAP];
	logic [rdsc_pkg::RADIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
